FILE: src/dfpe_pkg.sv
// Shared types and constants for the DShot frame pulse encoder.
package dfpe_pkg;

    localparam int FRAME_BITS    = 16;
    localparam int HIGH_W        = 8;
    localparam int LOW_W         = 13;
    localparam int VALUE_W       = 11;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 13;
    localparam int IDX_W         = $clog2(FRAME_BITS + 1);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [VALUE_W-1:0] THROTTLE_MIN = VALUE_W'(48);

    localparam logic [HIGH_W-1:0] ZERO_HIGH_RESET  = HIGH_W'(7);
    localparam logic [HIGH_W-1:0] ONE_HIGH_RESET   = HIGH_W'(14);
    localparam logic [HIGH_W-1:0] BIT_PERIOD_RESET = HIGH_W'(19);
    localparam logic [LOW_W-1:0]  GAP_RESET        = LOW_W'(3800);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP        = 2'd3;

    // Request opcodes
    localparam logic OP_THROTTLE = 1'b0;
    localparam logic OP_COMMAND  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [VALUE_W-1:0] value;
        logic               telemetry_request;
    } in_item_t;

    typedef struct packed {
        logic [HIGH_W-1:0] high_ticks;
        logic [LOW_W-1:0]  low_ticks;
        logic              error;
        logic              last;
    } out_item_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic                  error;
    } cmd_t;

    typedef struct packed {
        logic [HIGH_W-1:0] zero_high;
        logic [HIGH_W-1:0] one_high;
        logic [HIGH_W-1:0] bit_period;
        logic [LOW_W-1:0]  gap;
    } cfg_t;

endpackage

FILE: src/dfpe_front.sv
// Front end: range-checks a request and builds its 16-bit frame with checksum.
module dfpe_front (
    input  logic            in_valid,
    output logic            in_ready,
    input  dfpe_pkg::in_item_t in_item,
    output logic            push,
    input  logic            push_ready,
    output dfpe_pkg::cmd_t  push_cmd
);
    import dfpe_pkg::*;

    logic                        throttle;
    logic                        telem;
    logic [VALUE_W:0]            data_bits;
    logic [3:0]                  csum;

    always_comb
    begin
        throttle  = (in_item.opcode == OP_THROTTLE);
        // force telemetry off for throttle requests
        telem     = throttle ? 1'b0 : in_item.telemetry_request;
        data_bits = {in_item.value, telem};
        csum      = data_bits[3:0] ^ data_bits[7:4] ^ data_bits[11:8];

        push_cmd.frame = {data_bits, csum};
        push_cmd.error = throttle && (in_item.value != '0) && (in_item.value < THROTTLE_MIN);
    end

    assign push     = in_valid && push_ready;
    assign in_ready = push_ready;

endmodule

FILE: src/dfpe_queue.sv
// Short FIFO of classified requests between front and back.
module dfpe_queue #(
    parameter int DEPTH = dfpe_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           push_ready,
    input  dfpe_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output dfpe_pkg::cmd_t pop_cmd
);
    import dfpe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/dfpe_back.sv
// Back end: shifts a frame out as bit pulses plus a closing pause, or emits one error result for a rejected request.
module dfpe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  dfpe_pkg::cfg_t     cfg,
    input  logic               pop_valid,
    output logic               pop,
    input  dfpe_pkg::cmd_t     pop_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output dfpe_pkg::out_item_t out_item
);
    import dfpe_pkg::*;

    logic                  active_reg, active_next;
    logic                  err_reg, err_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg, out_item_next;

    logic                  advance;
    logic                  final_result;
    logic [HIGH_W-1:0]     hi;
    logic [HIGH_W-1:0]     lo;
    out_item_t             result;

    assign advance      = active_reg && (!out_valid_reg || out_ready);
    assign final_result = err_reg || (idx_reg == IDX_W'(FRAME_BITS));
    // load the next transaction as the current one finishes
    assign pop          = pop_valid && (!active_reg || (advance && final_result));

    always_comb
    begin
        hi = frame_reg[FRAME_BITS-1] ? cfg.one_high : cfg.zero_high;
        lo = (cfg.bit_period > hi) ? cfg.bit_period - hi : '0;

        if (err_reg)
        begin
            result.high_ticks = '0;
            result.low_ticks  = '0;
            result.error      = 1'b1;
            result.last       = 1'b1;
        end
        else if (idx_reg == IDX_W'(FRAME_BITS))
        begin
            result.high_ticks = '0;
            result.low_ticks  = cfg.gap;
            result.error      = 1'b0;
            result.last       = 1'b1;
        end
        else
        begin
            result.high_ticks = hi;
            result.low_ticks  = LOW_W'(lo);
            result.error      = 1'b0;
            result.last       = 1'b0;
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        err_next       = err_reg;
        frame_next     = frame_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (pop)
        begin
            active_next = 1'b1;
            err_next    = pop_cmd.error;
            frame_next  = pop_cmd.frame;
            idx_next    = '0;
        end
        else if (advance)
        begin
            if (final_result)
            begin
                active_next = 1'b0;
            end
            else
            begin
                frame_next = {frame_reg[FRAME_BITS-2:0], 1'b0};
                idx_next   = idx_reg + 1'b1;
            end
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_item_next  = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        frame_reg    <= frame_next;
        idx_reg      <= idx_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: src/dshot_frame_pulse_encoder_core.sv
// Top level of the DShot frame pulse encoder: config registers, front, queue, back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid / in_ready  | in_item: opcode, value, telemetry
//  out     | output    | out_valid / out_ready| out_item: high/low ticks, error, last
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A frame request yields 17 results, a rejected throttle yields 1; the back end
// emits one result per cycle while out_ready is high and a request is queued.
// Requests are classified in the cycle they are accepted and wait in a queue of
// QUEUE_DEPTH entries; input stays ready while the queue has room.
// Reset loads the tick registers with their defaults and empties the queue.
// A low out_ready holds the current result in the output register.
module dshot_frame_pulse_encoder_core #(
    parameter int QUEUE_DEPTH = dfpe_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dfpe_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dfpe_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [dfpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dfpe_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dfpe_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop;
    cmd_t pop_cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ZERO_HIGH:  cfg_next.zero_high  = cfg_data[HIGH_W-1:0];
                CFG_ONE_HIGH:   cfg_next.one_high   = cfg_data[HIGH_W-1:0];
                CFG_BIT_PERIOD: cfg_next.bit_period = cfg_data[HIGH_W-1:0];
                CFG_GAP:        cfg_next.gap        = cfg_data[LOW_W-1:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high  <= ZERO_HIGH_RESET;
            cfg_reg.one_high   <= ONE_HIGH_RESET;
            cfg_reg.bit_period <= BIT_PERIOD_RESET;
            cfg_reg.gap        <= GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dfpe_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    dfpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    dfpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

FILE: bench/dfpe_pulse_checker.sv
// Channel monitor, pulse train predictor and result comparison for the DShot frame encoder.
`timescale 1ns / 100ps

module dfpe_pulse_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  dfpe_pkg::in_item_t                  in_item,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  dfpe_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [dfpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dfpe_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int unsigned                         pending_pulses,
    output int unsigned                         mismatch_count
);

    import dfpe_pkg::*;

    cfg_t      timing;
    out_item_t pulse_q[$];

    task automatic queue_pulse_train(input in_item_t req);
        logic [VALUE_W:0]      data;
        logic [FRAME_BITS-1:0] frame;
        logic [HIGH_W-1:0]     hi;
        logic                  telem;
        out_item_t             pulse;
        int                    i;
        telem = req.telemetry_request;
        if (req.opcode == OP_THROTTLE && req.value != '0 && req.value < THROTTLE_MIN)
        begin
            // Rejected throttle: a single error marker, no frame
            pulse.high_ticks = '0;
            pulse.low_ticks  = '0;
            pulse.error      = 1'b1;
            pulse.last       = 1'b1;
            pulse_q.push_back(pulse);
        end
        else
        begin
            if (req.opcode == OP_THROTTLE)
                telem = 1'b0;
            data  = {req.value, telem};
            frame = {data, data[3:0] ^ data[7:4] ^ data[11:8]};
            for (i = FRAME_BITS - 1; i >= 0; i--)
            begin
                hi = frame[i] ? timing.one_high : timing.zero_high;
                pulse.high_ticks = hi;
                // Saturate the low time when the high time fills the bit
                pulse.low_ticks  = (timing.bit_period > hi) ?
                                   {5'b0, timing.bit_period - hi} : '0;
                pulse.error      = 1'b0;
                pulse.last       = 1'b0;
                pulse_q.push_back(pulse);
            end
            pulse.high_ticks = '0;
            pulse.low_ticks  = timing.gap;
            pulse.error      = 1'b0;
            pulse.last       = 1'b1;
            pulse_q.push_back(pulse);
        end
    endtask

    task automatic compare_pulse(input out_item_t got);
        out_item_t want;
        if (pulse_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected result hi=%0d lo=%0d err=%0b last=%0b",
                         $time, got.high_ticks, got.low_ticks, got.error, got.last);
        end
        else
        begin
            want = pulse_q.pop_front();
            if (got.high_ticks != want.high_ticks || got.low_ticks != want.low_ticks ||
                got.error != want.error || got.last != want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"%0t: result mismatch: expected hi=%0d lo=%0d err=%0b last=%0b,",
                              " got hi=%0d lo=%0d err=%0b last=%0b"},
                             $time, want.high_ticks, want.low_ticks, want.error, want.last,
                             got.high_ticks, got.low_ticks, got.error, got.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing.zero_high  = ZERO_HIGH_RESET;
            timing.one_high   = ONE_HIGH_RESET;
            timing.bit_period = BIT_PERIOD_RESET;
            timing.gap        = GAP_RESET;
            pulse_q.delete();
            mismatch_count = 0;
            pending_pulses <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                compare_pulse(out_item);
            if (in_valid && in_ready)
                queue_pulse_train(in_item);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ZERO_HIGH:  timing.zero_high  = cfg_data[HIGH_W-1:0];
                    CFG_ONE_HIGH:   timing.one_high   = cfg_data[HIGH_W-1:0];
                    CFG_BIT_PERIOD: timing.bit_period = cfg_data[HIGH_W-1:0];
                    CFG_GAP:        timing.gap        = cfg_data[LOW_W-1:0];
                    default:        ;
                endcase
            end
            pending_pulses <= pulse_q.size();
        end
    end

endmodule

FILE: bench/dshot_frame_pulse_encoder_core_tb.sv
// Stimulus, flow control and verdict for the DShot frame pulse encoder core.
`timescale 1ns / 100ps

module dshot_frame_pulse_encoder_core_tb;

    import dfpe_pkg::*;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_item   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_item;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int unsigned            pending_pulses;
    int unsigned            mismatch_count;
    int                     burst_left = 0;

    always #2 clk = ~clk;

    dshot_frame_pulse_encoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dfpe_pulse_checker pulse_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending_pulses (pending_pulses),
        .mismatch_count (mismatch_count)
    );

    function automatic in_item_t make_request(input logic op, input logic [VALUE_W-1:0] val,
                                              input logic telem);
        in_item_t req;
        req.opcode            = op;
        req.value             = val;
        req.telemetry_request = telem;
        return req;
    endfunction

    function automatic in_item_t random_request();
        int       pick;
        in_item_t req;
        pick = $urandom_range(0, 99);
        req.telemetry_request = 1'($urandom_range(0, 1));
        if (pick < 55)
            req = make_request(OP_THROTTLE, VALUE_W'($urandom_range(48, 2047)),
                               req.telemetry_request);
        else if (pick < 62)
            req = make_request(OP_THROTTLE, '0, req.telemetry_request);
        else if (pick < 72)
            req = make_request(OP_THROTTLE, VALUE_W'($urandom_range(1, 47)),
                               req.telemetry_request);
        else
            req = make_request(OP_COMMAND, VALUE_W'($urandom_range(0, 2047)),
                               req.telemetry_request);
        return req;
    endfunction

    function automatic int pick_gap();
        int pick;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (pick < 9)
            return 0;
        if (pick < 17)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Present one request and hold it until it is accepted
    task automatic send_request(input in_item_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_request(random_request());
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending_pulses != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Upper data bits are don't-care for the 8-bit tick registers
    task automatic program_timing(input logic [HIGH_W-1:0] zero_hi,
                                  input logic [HIGH_W-1:0] one_hi,
                                  input logic [HIGH_W-1:0] period,
                                  input logic [LOW_W-1:0] gap,
                                  input logic [4:0] pad);
        write_reg(CFG_ZERO_HIGH, {pad, zero_hi});
        write_reg(CFG_ONE_HIGH, {~pad, one_hi});
        write_reg(CFG_BIT_PERIOD, {pad, period});
        write_reg(CFG_GAP, gap);
        cfg_we <= 1'b0;
    endtask

    // Randomly throttle the result side: short and long stalls, plus free-running stretches
    initial
    begin
        forever
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(40, 200)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1'b0;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and range edges under the reset timing
        send_request(make_request(OP_THROTTLE, 11'd0,    1'b1));
        send_request(make_request(OP_THROTTLE, 11'd1,    1'b0));
        send_request(make_request(OP_THROTTLE, 11'd47,   1'b1));
        send_request(make_request(OP_THROTTLE, 11'd48,   1'b1));
        send_request(make_request(OP_THROTTLE, 11'd2047, 1'b1));
        send_request(make_request(OP_THROTTLE, 11'd1000, 1'b0));
        send_request(make_request(OP_THROTTLE, 11'h555,  1'b0));
        send_request(make_request(OP_THROTTLE, 11'h2aa,  1'b1));
        send_request(make_request(OP_COMMAND,  11'd0,    1'b0));
        send_request(make_request(OP_COMMAND,  11'd0,    1'b1));
        send_request(make_request(OP_COMMAND,  11'd2047, 1'b0));
        send_request(make_request(OP_COMMAND,  11'd2047, 1'b1));
        send_request(make_request(OP_COMMAND,  11'd1,    1'b1));
        send_request(make_request(OP_COMMAND,  11'd47,   1'b0));
        send_request(make_request(OP_COMMAND,  11'h555,  1'b1));
        send_request(make_request(OP_COMMAND,  11'h2aa,  1'b0));
        send_random(34);
        wait_idle();

        // Shortest period: the one bit saturates, the zero bit fills half the period, no pause
        program_timing(8'd1, 8'd255, 8'd2, 13'd0, 5'd0);
        send_random(52);
        wait_idle();

        // Longest ticks: zero bit fills the period exactly, longest pause
        program_timing(8'd255, 8'd1, 8'd255, 13'd8191, 5'h1f);
        send_random(52);
        wait_idle();

        for (phase = 0; phase < 3; phase++)
        begin
            program_timing(HIGH_W'($urandom_range(1, 255)), HIGH_W'($urandom_range(1, 255)),
                           HIGH_W'($urandom_range(2, 255)), LOW_W'($urandom_range(0, 8191)),
                           5'($urandom_range(0, 31)));
            send_random(52);
            wait_idle();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_pulses == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
